/* hw/rtl/maze_backtracker_generator_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the maze generator
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MAZE_BACKTRACKER_GENERATOR_TOP_DEFINES_SVH
`define MAZE_BACKTRACKER_GENERATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent holds -> consequent holds in the same cycle
`define MBG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// antecedent holds -> consequent holds in the next cycle
`define MBG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBG_ASSERT_IMP(lbl, ante, cons, msg)
`define MBG_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/mbg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_pkg
// Shared types, constants and helper functions of the maze generator.
// ----------------------------------------------------------------------------
package mbg_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    localparam int CFG_DIM_W  = 7;
    localparam int DIM_W      = 9;   // holds a clamped dimension up to 511
    localparam int SEED_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int WALL_W     = 4;
    localparam int CELL_W     = WALL_W + 1;  // {visited, walls}
    localparam int ORDER_W    = 8;
    localparam int NEXT_W     = 3;

    localparam logic [SEED_W-1:0]    LFSR_TAPS  = 32'h8020_0003;
    localparam logic [WALL_W-1:0]    ALL_WALLS  = 4'hF;
    localparam logic [CFG_DIM_W-1:0] RESET_DIM  = 7'd16;
    localparam logic [SEED_W-1:0]    RESET_SEED = 32'd1;

    typedef enum logic {
        OP_GENERATE = 1'b0,
        OP_QUERY    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_RANDOM_SEED = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_ENTER,
        ST_SHUFFLE,
        ST_STEP,
        ST_NB_WAIT,
        ST_POP_WAIT,
        ST_GEN_RESP
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0]  cols;
        logic [DIM_W-1:0]  rows;
        logic [SEED_W-1:0] seed;
    } cfg_t;

    typedef logic [3:0][1:0] order_t;
    localparam order_t ORDER_INIT = 8'b11_10_01_00;

    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    // 4 == 1 mod 3, so the sum of the base-4 digits keeps the residue
    function automatic logic [1:0] mod3_32(input logic [SEED_W-1:0] v);
        logic [2:0] s1 [8];
        logic [3:0] s2 [4];
        logic [4:0] s3 [2];
        logic [5:0] s4;
        logic [3:0] r;
        for (int i = 0; i < 8; i++) begin
            s1[i] = 3'(v[4*i +: 2]) + 3'(v[4*i+2 +: 2]);
        end
        for (int i = 0; i < 4; i++) begin
            s2[i] = 4'(s1[2*i]) + 4'(s1[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            s3[i] = 5'(s2[2*i]) + 5'(s2[2*i+1]);
        end
        s4 = 6'(s3[0]) + 6'(s3[1]);
        r  = 4'(s4[1:0]) + 4'(s4[3:2]) + 4'(s4[5:4]);
        if (r >= 4'd6) begin
            r = r - 4'd6;
        end
        if (r >= 4'd3) begin
            r = r - 4'd3;
        end
        return r[1:0];
    endfunction

    function automatic logic [WALL_W-1:0] wall_bit(input dir_t d);
        return 4'b0001 << d;
    endfunction

    function automatic dir_t opp_dir(input dir_t d);
        logic [1:0] t;
        t = d + 2'd2;
        return dir_t'(t);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (DIM_W'(v) > maxv) begin
            r = maxv;
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/mbg_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbg_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 5
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/mbg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "maze_backtracker_generator_top_defines.svh"
// ----------------------------------------------------------------------------
// mbg_ctrl
// Sequencer: clear sweep, shuffle, depth-first walk, queries, result register.
// ----------------------------------------------------------------------------
module mbg_ctrl
    import mbg_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int COL_W       = $clog2(MAX_COLUMNS),
    parameter int ROW_W       = $clog2(MAX_ROWS),
    parameter int ADDR_W      = COL_W + ROW_W,
    parameter int FRAME_W     = COL_W + ROW_W + ORDER_W + NEXT_W + WALL_W
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_op,
    input  wire logic [5:0]         s_cell_x,
    input  wire logic [5:0]         s_cell_y,
    input  wire logic [1:0]         s_direction,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [WALL_W-1:0]       m_wall_mask,
    output logic                    m_passage_open,
    output logic                    m_generate_done,

    output logic                    cell_wr_en,
    output logic [ADDR_W-1:0]       cell_wr_addr,
    output logic [CELL_W-1:0]       cell_wr_data,
    output logic                    cell_rd_en,
    output logic [ADDR_W-1:0]       cell_rd_addr,
    input  wire logic [CELL_W-1:0]  cell_rd_data,

    output logic                    stk_wr_en,
    output logic [ADDR_W-1:0]       stk_wr_addr,
    output logic [FRAME_W-1:0]      stk_wr_data,
    output logic                    stk_rd_en,
    output logic [ADDR_W-1:0]       stk_rd_addr,
    input  wire logic [FRAME_W-1:0] stk_rd_data
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                gen_pending_reg;
    logic [SEED_W-1:0]   lfsr_reg;
    logic [COL_W-1:0]    cur_x_reg;
    logic [ROW_W-1:0]    cur_y_reg;
    logic [WALL_W-1:0]   cur_walls_reg;
    order_t              order_reg;
    logic [NEXT_W-1:0]   next_reg;
    logic [1:0]          shuf_i_reg;
    logic [ADDR_W-1:0]   depth_reg;
    dir_t                dir_reg;
    logic [COL_W-1:0]    nb_x_reg;
    logic [ROW_W-1:0]    nb_y_reg;
    logic                q_inside_reg;
    logic [1:0]          q_dir_reg;
    logic                m_valid_reg;
    logic [WALL_W-1:0]   m_wall_mask_reg;
    logic                m_open_reg;
    logic                m_done_reg;

    logic                out_free;
    logic                load_result;
    logic                top_done;
    dir_t                step_dir;
    logic                nb_ok;
    logic [COL_W-1:0]    nb_x;
    logic [ROW_W-1:0]    nb_y;
    logic [SEED_W-1:0]   draw;
    logic [1:0]          swap_j;
    order_t              order_swapped;
    logic [WALL_W-1:0]   q_mask;
    logic                nb_visited;
    logic                q_inside;

    assign out_free    = !m_valid_reg || m_ready;
    assign load_result = ((state_reg == ST_QUERY) || (state_reg == ST_GEN_RESP)) && out_free;
    assign top_done    = next_reg[2];
    assign nb_visited  = cell_rd_data[CELL_W-1];
    assign q_mask      = q_inside_reg ? cell_rd_data[WALL_W-1:0] : ALL_WALLS;
    assign q_inside    = (DIM_W'(s_cell_x) < cfg.cols) && (DIM_W'(s_cell_y) < cfg.rows);

    assign m_valid         = m_valid_reg;
    assign m_wall_mask     = m_wall_mask_reg;
    assign m_passage_open  = m_open_reg;
    assign m_generate_done = m_done_reg;

    // neighbor of the current cell in the next shuffled direction
    always_comb begin
        step_dir = dir_t'(order_reg[next_reg[1:0]]);
        nb_x     = cur_x_reg;
        nb_y     = cur_y_reg;
        nb_ok    = 1'b0;
        unique case (step_dir)
            DIR_N: begin
                nb_ok = (cur_y_reg != '0);
                nb_y  = cur_y_reg - ROW_W'(1);
            end
            DIR_E: begin
                nb_ok = (DIM_W'(cur_x_reg) + DIM_W'(1)) < cfg.cols;
                nb_x  = cur_x_reg + COL_W'(1);
            end
            DIR_S: begin
                nb_ok = (DIM_W'(cur_y_reg) + DIM_W'(1)) < cfg.rows;
                nb_y  = cur_y_reg + ROW_W'(1);
            end
            DIR_W: begin
                nb_ok = (cur_x_reg != '0);
                nb_x  = cur_x_reg - COL_W'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // one Fisher-Yates swap per cycle, i = 3, 2, 1
    always_comb begin
        draw = lfsr_step(lfsr_reg);
        unique case (shuf_i_reg)
            2'd3:    swap_j = draw[1:0];
            2'd2:    swap_j = mod3_32(draw);
            default: swap_j = {1'b0, draw[0]};
        endcase
        order_swapped             = order_reg;
        order_swapped[shuf_i_reg] = order_reg[swap_j];
        order_swapped[swap_j]     = order_reg[shuf_i_reg];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == '1) begin
                    state_next = gen_pending_reg ? ST_ENTER : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_QUERY) ? ST_QUERY : ST_CLEAR;
                end
            end
            ST_QUERY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ENTER: state_next = ST_SHUFFLE;
            ST_SHUFFLE: begin
                if (shuf_i_reg == 2'd1) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (top_done) begin
                    state_next = (depth_reg == '0) ? ST_GEN_RESP : ST_POP_WAIT;
                end else if (nb_ok) begin
                    state_next = ST_NB_WAIT;
                end
            end
            ST_NB_WAIT:  state_next = nb_visited ? ST_STEP : ST_ENTER;
            ST_POP_WAIT: state_next = ST_STEP;
            ST_GEN_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory ports and handshake
    always_comb begin
        s_ready      = 1'b0;
        cell_wr_en   = 1'b0;
        cell_wr_addr = {cur_y_reg, cur_x_reg};
        cell_wr_data = {1'b1, cur_walls_reg};
        cell_rd_en   = 1'b0;
        cell_rd_addr = {nb_y, nb_x};
        stk_wr_en    = 1'b0;
        stk_wr_addr  = depth_reg;
        stk_wr_data  = {cur_x_reg, cur_y_reg, order_reg, next_reg,
                        cur_walls_reg & ~wall_bit(dir_reg)};
        stk_rd_en    = 1'b0;
        stk_rd_addr  = depth_reg - ADDR_W'(1);
        unique case (state_reg)
            ST_CLEAR: begin
                cell_wr_en   = 1'b1;
                cell_wr_addr = clr_addr_reg;
                cell_wr_data = {1'b0, ALL_WALLS};
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                cell_rd_en   = s_valid;
                cell_rd_addr = {ROW_W'(s_cell_y), COL_W'(s_cell_x)};
            end
            ST_ENTER: begin
                cell_wr_en = 1'b1;
            end
            ST_STEP: begin
                cell_rd_en = !top_done && nb_ok;
                stk_rd_en  = top_done && (depth_reg != '0);
            end
            ST_NB_WAIT: begin
                // carve: current cell's wall goes, frame is pushed
                cell_wr_en   = !nb_visited;
                cell_wr_data = {1'b1, cur_walls_reg & ~wall_bit(dir_reg)};
                stk_wr_en    = !nb_visited;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            gen_pending_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            lfsr_reg        <= RESET_SEED;
            depth_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == '1) begin
                        lfsr_reg      <= cfg.seed;
                        cur_x_reg     <= '0;
                        cur_y_reg     <= '0;
                        cur_walls_reg <= ALL_WALLS;
                        depth_reg     <= '0;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_op == OP_QUERY) begin
                            q_inside_reg <= q_inside;
                            q_dir_reg    <= s_direction;
                        end else begin
                            gen_pending_reg <= 1'b1;
                            clr_addr_reg    <= '0;
                        end
                    end
                end
                ST_QUERY: begin
                    if (out_free) begin
                        m_wall_mask_reg <= q_mask;
                        m_open_reg      <= !q_mask[q_dir_reg];
                        m_done_reg      <= 1'b0;
                    end
                end
                ST_ENTER: begin
                    order_reg  <= ORDER_INIT;
                    next_reg   <= '0;
                    shuf_i_reg <= 2'd3;
                end
                ST_SHUFFLE: begin
                    lfsr_reg   <= draw;
                    order_reg  <= order_swapped;
                    shuf_i_reg <= shuf_i_reg - 2'd1;
                end
                ST_STEP: begin
                    if (!top_done) begin
                        next_reg <= next_reg + NEXT_W'(1);
                        dir_reg  <= step_dir;
                        nb_x_reg <= nb_x;
                        nb_y_reg <= nb_y;
                    end else if (depth_reg != '0) begin
                        depth_reg <= depth_reg - ADDR_W'(1);
                    end
                end
                ST_NB_WAIT: begin
                    if (!nb_visited) begin
                        depth_reg     <= depth_reg + ADDR_W'(1);
                        cur_x_reg     <= nb_x_reg;
                        cur_y_reg     <= nb_y_reg;
                        cur_walls_reg <= ALL_WALLS & ~wall_bit(opp_dir(dir_reg));
                    end
                end
                ST_POP_WAIT: begin
                    {cur_x_reg, cur_y_reg, order_reg, next_reg, cur_walls_reg} <= stk_rd_data;
                end
                ST_GEN_RESP: begin
                    if (out_free) begin
                        m_wall_mask_reg <= '0;
                        m_open_reg      <= 1'b0;
                        m_done_reg      <= 1'b1;
                        gen_pending_reg <= 1'b0;
                    end
                end
                default: begin
                    gen_pending_reg <= gen_pending_reg;
                end
            endcase
        end
    end

    `MBG_ASSERT_IMP(a_cell_no_rw_overlap, cell_wr_en && cell_rd_en, cell_wr_addr != cell_rd_addr, "cell RAM read and write collide")
    `MBG_ASSERT_IMP(a_pop_nonempty, stk_rd_en, depth_reg != '0, "pop from empty walk stack")
    `MBG_ASSERT_IMP(a_push_room, stk_wr_en, depth_reg != '1, "walk stack overflow")
    `MBG_ASSERT_IMP(a_nb_after_step, state_reg == ST_NB_WAIT, $past(state_reg) == ST_STEP, "neighbor check without lookup")
    `MBG_ASSERT_NXT(a_gen_result, state_reg == ST_GEN_RESP && out_free, m_valid_reg && m_done_reg, "generate result not posted")

endmodule
`default_nettype wire

/* hw/rtl/maze_backtracker_generator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maze_backtracker_generator_top
// Depth-first backtracking maze generator with a per-cell wall query port.
// ----------------------------------------------------------------------------
// Input channel s_*: op 0 regenerates the maze, op 1 queries cell
// (cell_x, cell_y) and direction. Each item yields one result beat on m_*.
// Query: the cell RAM read is registered and the result register follows it;
// the next item is taken only once the previous query has loaded its result.
// Generate: a sweep over all 2**(clog2(MAX_COLUMNS)+clog2(MAX_ROWS)) cell
// addresses (4096 at 64x64) restores all walls, then the walk visits each
// grid cell with one enter write, three shuffle steps, one probe per direction,
// one RAM lookup per in-grid neighbor and, but for the first cell, a stack pop.
// Reset: the same clearing sweep runs after reset; s_ready stays low for it.
// cfg_wr_en/cfg_index/cfg_data write width, height and seed, and are to
// be used only while no item is in flight.
// A stalled m_ready holds the result register; the next item may still be
// accepted and is worked on, its result waiting until the register frees.
// ----------------------------------------------------------------------------
module maze_backtracker_generator_top
    import mbg_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SEED_W-1:0]    cfg_data,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_op,
    input  wire logic [5:0]           s_cell_x,
    input  wire logic [5:0]           s_cell_y,
    input  wire logic [1:0]           s_direction,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [WALL_W-1:0]         m_wall_mask,
    output logic                      m_passage_open,
    output logic                      m_generate_done
);

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int FRAME_W = COL_W + ROW_W + ORDER_W + NEXT_W + WALL_W;

    cfg_t                cfg_reg;
    logic                cell_wr_en, cell_rd_en, stk_wr_en, stk_rd_en;
    logic [ADDR_W-1:0]   cell_wr_addr, cell_rd_addr, stk_wr_addr, stk_rd_addr;
    logic [CELL_W-1:0]   cell_wr_data, cell_rd_data;
    logic [FRAME_W-1:0]  stk_wr_data, stk_rd_data;

    // dimensions are stored clamped, a zero seed as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cols <= clamp_dim(RESET_DIM, DIM_W'(MAX_COLUMNS));
            cfg_reg.rows <= clamp_dim(RESET_DIM, DIM_W'(MAX_ROWS));
            cfg_reg.seed <= RESET_SEED;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  cfg_reg.cols <= clamp_dim(cfg_data[CFG_DIM_W-1:0],
                                                           DIM_W'(MAX_COLUMNS));
                REG_GRID_HEIGHT: cfg_reg.rows <= clamp_dim(cfg_data[CFG_DIM_W-1:0],
                                                           DIM_W'(MAX_ROWS));
                REG_RANDOM_SEED: cfg_reg.seed <= (cfg_data == '0) ? RESET_SEED : cfg_data;
                default:         cfg_reg      <= cfg_reg;
            endcase
        end
    end

    mbg_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .COL_W       (COL_W),
        .ROW_W       (ROW_W),
        .ADDR_W      (ADDR_W),
        .FRAME_W     (FRAME_W)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_cell_x        (s_cell_x),
        .s_cell_y        (s_cell_y),
        .s_direction     (s_direction),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_wall_mask     (m_wall_mask),
        .m_passage_open  (m_passage_open),
        .m_generate_done (m_generate_done),
        .cell_wr_en      (cell_wr_en),
        .cell_wr_addr    (cell_wr_addr),
        .cell_wr_data    (cell_wr_data),
        .cell_rd_en      (cell_rd_en),
        .cell_rd_addr    (cell_rd_addr),
        .cell_rd_data    (cell_rd_data),
        .stk_wr_en       (stk_wr_en),
        .stk_wr_addr     (stk_wr_addr),
        .stk_wr_data     (stk_wr_data),
        .stk_rd_en       (stk_rd_en),
        .stk_rd_addr     (stk_rd_addr),
        .stk_rd_data     (stk_rd_data)
    );

    // visited flag and wall mask per cell
    mbg_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (cell_wr_en),
        .wr_addr (cell_wr_addr),
        .wr_data (cell_wr_data),
        .rd_en   (cell_rd_en),
        .rd_addr (cell_rd_addr),
        .rd_data (cell_rd_data)
    );

    // saved walk frames below the current cell
    mbg_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (FRAME_W)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

endmodule
`default_nettype wire

/* dv/tb_maze_backtracker_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_maze_backtracker_generator_top
// Self-checking bench for the backtracking maze generator. A short directed
// table covers reset contents, grid extremes, clamped sizes, zero seed and
// off-grid queries. Random phases follow: new sizes, often new seeds, mostly
// a generate, then bursts of cell queries. Every reply beat is compared with
// an in-bench maze model that carves the same grid from the same LFSR.
// ----------------------------------------------------------------------------
module tb_maze_backtracker_generator_top;
    import mbg_pkg::*;

    localparam int          COLS           = DEF_MAX_COLUMNS;
    localparam int          ROWS           = DEF_MAX_ROWS;
    localparam int          CELLS          = COLS * ROWS;
    localparam int unsigned ITEM_TARGET    = 1425;
    localparam int unsigned TAIL_ITEMS     = 150;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT    = 3_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // no register behind it

    typedef struct packed {
        logic [WALL_W-1:0] wall_mask;
        logic              passage_open;
        logic              generate_done;
    } cell_reply_t;

    typedef struct packed {
        logic [5:0]      x;
        logic [5:0]      y;
        logic [3:0][1:0] order;
        logic [2:0]      next;
    } walk_frame_t;

    typedef struct packed {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [SEED_W-1:0]    reg_data;
        op_t                  op;
        logic [5:0]           x;
        logic [5:0]           y;
        dir_t                 dir;
        bit                   typed;
        cell_reply_t          want;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SEED_W-1:0]    cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_op        = 1'b0;
    logic [5:0]           s_cell_x    = '0;
    logic [5:0]           s_cell_y    = '0;
    logic [1:0]           s_direction = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [WALL_W-1:0]    m_wall_mask;
    logic                 m_passage_open;
    logic                 m_generate_done;

    // maze model state
    logic [WALL_W-1:0] maze_walls [CELLS];
    bit                visited [CELLS];
    walk_frame_t       walk_frames [CELLS];
    int unsigned       walk_depth;
    logic [SEED_W-1:0] maze_lfsr;
    logic [CFG_DIM_W-1:0] cfg_cols;
    logic [CFG_DIM_W-1:0] cfg_rows;
    logic [SEED_W-1:0]    cfg_seed;

    cell_reply_t pending_replies [$];
    cell_reply_t reply_head;
    plan_row_t   directed_plan [$];

    int unsigned items_sent  = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned rx_left     = 0;
    int unsigned hold_asks   = 0;
    int unsigned hold_served = 0;

    always #4 aclk = ~aclk;

    maze_backtracker_generator_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_cell_x        (s_cell_x),
        .s_cell_y        (s_cell_y),
        .s_direction     (s_direction),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_wall_mask     (m_wall_mask),
        .m_passage_open  (m_passage_open),
        .m_generate_done (m_generate_done)
    );

    function automatic int unsigned fit_dim(input logic [CFG_DIM_W-1:0] v,
                                            input int unsigned lim);
        if (v == '0) begin
            return 1;
        end
        if (v > lim) begin
            return lim;
        end
        return 32'(v);
    endfunction

    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
    endfunction

    // push a frame for the cell and shuffle its direction order
    function automatic void open_cell(input int unsigned cx, input int unsigned cy);
        logic [1:0]  tmp;
        int unsigned j;
        if (walk_depth >= CELLS) begin
            return;
        end
        visited[cy * COLS + cx] = 1'b1;
        walk_frames[walk_depth].x    = 6'(cx);
        walk_frames[walk_depth].y    = 6'(cy);
        walk_frames[walk_depth].next = '0;
        for (int i = 0; i < 4; i++) begin
            walk_frames[walk_depth].order[i] = 2'(i);
        end
        for (int i = 3; i > 0; i--) begin
            maze_lfsr = lfsr_next(maze_lfsr);
            j = maze_lfsr % (i + 1);
            tmp = walk_frames[walk_depth].order[i];
            walk_frames[walk_depth].order[i] = walk_frames[walk_depth].order[j];
            walk_frames[walk_depth].order[j] = tmp;
        end
        walk_depth++;
    endfunction

    function automatic void carve_maze();
        int unsigned w;
        int unsigned h;
        int unsigned top;
        int          nx;
        int          ny;
        logic [1:0]  d;
        logic [1:0]  back;
        w = fit_dim(cfg_cols, COLS);
        h = fit_dim(cfg_rows, ROWS);
        for (int i = 0; i < CELLS; i++) begin
            maze_walls[i] = ALL_WALLS;
            visited[i]    = 1'b0;
        end
        maze_lfsr  = (cfg_seed == '0) ? 32'd1 : cfg_seed;
        walk_depth = 0;
        open_cell(0, 0);
        while (walk_depth > 0) begin
            top = walk_depth - 1;
            if (walk_frames[top].next >= 4) begin
                walk_depth--;
                continue;
            end
            d = walk_frames[top].order[walk_frames[top].next[1:0]];
            walk_frames[top].next = walk_frames[top].next + 3'd1;
            nx = int'(walk_frames[top].x) + ((d == DIR_E) ? 1 : (d == DIR_W) ? -1 : 0);
            ny = int'(walk_frames[top].y) + ((d == DIR_S) ? 1 : (d == DIR_N) ? -1 : 0);
            if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) begin
                continue;
            end
            if (visited[ny * COLS + nx]) begin
                continue;
            end
            back = d + 2'd2;
            maze_walls[int'(walk_frames[top].y) * COLS + int'(walk_frames[top].x)][d] = 1'b0;
            maze_walls[ny * COLS + nx][back] = 1'b0;
            open_cell(nx, ny);
        end
    endfunction

    function automatic cell_reply_t predict_reply(input op_t op, input logic [5:0] x,
                                                  input logic [5:0] y, input dir_t dir);
        cell_reply_t r;
        r = '0;
        if (op == OP_GENERATE) begin
            carve_maze();
            r.generate_done = 1'b1;
        end else begin
            r.wall_mask = ALL_WALLS;
            if (x < fit_dim(cfg_cols, COLS) && y < fit_dim(cfg_rows, ROWS)) begin
                r.wall_mask = maze_walls[int'(y) * COLS + int'(x)];
            end
            r.passage_open = ~r.wall_mask[dir];
        end
        return r;
    endfunction

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [SEED_W-1:0] data);
        plan_row_t row;
        row          = '0;
        row.is_reg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_item(input op_t op, input logic [5:0] x,
                                      input logic [5:0] y, input dir_t dir);
        plan_row_t row;
        row     = '0;
        row.op  = op;
        row.x   = x;
        row.y   = y;
        row.dir = dir;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_known(input op_t op, input logic [5:0] x,
                                       input logic [5:0] y, input dir_t dir,
                                       input logic [WALL_W-1:0] mask,
                                       input logic open, input logic done);
        plan_row_t row;
        row       = '0;
        row.op    = op;
        row.x     = x;
        row.y     = y;
        row.dir   = dir;
        row.typed = 1'b1;
        row.want  = '{wall_mask: mask, passage_open: open, generate_done: done};
        directed_plan.push_back(row);
    endfunction

    // valid stays up between back-to-back beats; it drops for a gap or in wait_replies
    task automatic send_item(input op_t op, input logic [5:0] x, input logic [5:0] y,
                             input dir_t dir, input bit typed, input cell_reply_t want);
        cell_reply_t r;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_cell_x    <= x;
        s_cell_y    <= y;
        s_direction <= dir;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        r = predict_reply(op, x, y, dir);
        pending_replies.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic wait_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEED_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_GRID_WIDTH:  cfg_cols = data[CFG_DIM_W-1:0];
            REG_GRID_HEIGHT: cfg_rows = data[CFG_DIM_W-1:0];
            REG_RANDOM_SEED: cfg_seed = data;
            default: ;
        endcase
    endtask

    // reply side: random stall bursts, plus one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_left <= 0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
            m_ready <= (rx_left == 1);
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_asks;
            rx_left     <= RX_HOLD_CYCLES - 1;
            m_ready     <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_left <= $urandom_range(1, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("reply beat with nothing pending: wall_mask %0h open %0b done %0b",
                       m_wall_mask, m_passage_open, m_generate_done);
                error_count++;
            end else begin
                reply_head = pending_replies.pop_front();
                if (m_wall_mask !== reply_head.wall_mask) begin
                    $error("wall_mask: expected %0h, got %0h",
                           reply_head.wall_mask, m_wall_mask);
                    error_count++;
                end
                if (m_passage_open !== reply_head.passage_open) begin
                    $error("passage_open: expected %0b, got %0b",
                           reply_head.passage_open, m_passage_open);
                    error_count++;
                end
                if (m_generate_done !== reply_head.generate_done) begin
                    $error("generate_done: expected %0b, got %0b",
                           reply_head.generate_done, m_generate_done);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int unsigned          phase;
        int unsigned          big_grids;
        int unsigned          batch;
        int unsigned          roll;
        int unsigned          w;
        int unsigned          h;
        bit                   quiet;
        logic [CFG_DIM_W-1:0] cols;
        logic [CFG_DIM_W-1:0] rows;
        logic [SEED_W-1:0]    data;
        logic [5:0]           x;
        plan_row_t            row;

        for (int i = 0; i < CELLS; i++) begin
            maze_walls[i] = ALL_WALLS;
            visited[i]    = 1'b0;
        end
        walk_depth = 0;
        maze_lfsr  = 32'd1;
        cfg_cols   = RESET_DIM;
        cfg_rows   = RESET_DIM;
        cfg_seed   = RESET_SEED;

        // untouched since reset: every wall stands
        plan_known(OP_QUERY, 0, 0, DIR_N, ALL_WALLS, 1'b0, 1'b0);
        plan_known(OP_QUERY, 63, 63, DIR_W, ALL_WALLS, 1'b0, 1'b0);
        plan_known(OP_QUERY, 15, 15, DIR_S, ALL_WALLS, 1'b0, 1'b0);
        plan_known(OP_GENERATE, 63, 0, DIR_E, '0, 1'b0, 1'b1);
        plan_item(OP_QUERY, 0, 0, DIR_N);
        plan_item(OP_QUERY, 0, 0, DIR_W);
        plan_item(OP_QUERY, 15, 15, DIR_E);
        plan_item(OP_QUERY, 15, 15, DIR_S);
        plan_known(OP_QUERY, 16, 0, DIR_E, ALL_WALLS, 1'b0, 1'b0);
        plan_known(OP_QUERY, 0, 16, DIR_N, ALL_WALLS, 1'b0, 1'b0);
        for (int d = 0; d < 4; d++) begin
            plan_item(OP_QUERY, 7, 9, dir_t'(d));
        end
        // zero sizes act as 1x1, zero seed as 1: nothing to carve
        plan_reg(REG_GRID_WIDTH, 32'd0);
        plan_reg(REG_GRID_HEIGHT, 32'hFFFF_FF80);
        plan_reg(REG_RANDOM_SEED, 32'd0);
        plan_known(OP_GENERATE, 0, 0, DIR_N, '0, 1'b0, 1'b1);
        plan_known(OP_QUERY, 0, 0, DIR_S, ALL_WALLS, 1'b0, 1'b0);
        plan_known(OP_QUERY, 1, 0, DIR_W, ALL_WALLS, 1'b0, 1'b0);
        // 2x1: the only wall between the two cells must go
        plan_reg(REG_GRID_WIDTH, 32'd2);
        plan_reg(REG_GRID_HEIGHT, 32'd1);
        plan_reg(REG_RANDOM_SEED, 32'h9E37_79B9);
        plan_reg(REG_SPARE, 32'h0000_007F);
        plan_known(OP_GENERATE, 5, 5, DIR_S, '0, 1'b0, 1'b1);
        plan_known(OP_QUERY, 0, 0, DIR_E, 4'hD, 1'b1, 1'b0);
        plan_known(OP_QUERY, 1, 0, DIR_W, 4'h7, 1'b1, 1'b0);
        // oversize values clamp to the full array
        plan_reg(REG_GRID_WIDTH, 32'd127);
        plan_reg(REG_GRID_HEIGHT, 32'd100);
        plan_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
        plan_known(OP_GENERATE, 0, 63, DIR_W, '0, 1'b0, 1'b1);
        plan_item(OP_QUERY, 63, 63, DIR_E);
        plan_item(OP_QUERY, 63, 0, DIR_N);
        plan_item(OP_QUERY, 0, 63, DIR_S);
        plan_item(OP_QUERY, 31, 32, DIR_W);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 15;
        rx_idle_pct <= 15;

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.is_reg) begin
                wait_replies();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_item(row.op, row.x, row.y, row.dir, row.typed, row.want);
            end
        end

        phase     = 0;
        big_grids = 0;
        while (items_sent < ITEM_TARGET) begin
            quiet = (items_sent + TAIL_ITEMS >= ITEM_TARGET);
            wait_replies();

            roll = $urandom_range(0, 19);
            if (roll < 14) begin
                cols = 7'($urandom_range(1, 10));
                rows = 7'($urandom_range(1, 10));
            end else if (roll < 17) begin
                cols = 7'($urandom_range(11, 24));
                rows = 7'($urandom_range(1, 24));
            end else if (roll < 19) begin
                // one-cell strip along a full, clamped side
                if ($urandom_range(0, 1) != 0) begin
                    cols = 7'($urandom_range(64, 127));
                    rows = 7'($urandom_range(0, 1));
                end else begin
                    cols = 7'($urandom_range(0, 1));
                    rows = 7'($urandom_range(64, 127));
                end
            end else if (big_grids < 2) begin
                cols = 7'($urandom_range(64, 127));
                rows = 7'($urandom_range(62, 127));
                big_grids++;
            end else begin
                cols = 7'd0;
                rows = 7'($urandom_range(2, 8));
            end
            data = $urandom;
            data[CFG_DIM_W-1:0] = cols;
            write_reg(REG_GRID_WIDTH, data);
            data = $urandom;
            data[CFG_DIM_W-1:0] = rows;
            write_reg(REG_GRID_HEIGHT, data);
            roll = $urandom_range(0, 19);
            if (roll < 2) begin
                write_reg(REG_RANDOM_SEED, 32'd0);
            end else if (roll == 2) begin
                write_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
            end else if (roll < 17) begin
                write_reg(REG_RANDOM_SEED, $urandom);
            end
            if ($urandom_range(0, 6) == 0) begin
                write_reg(REG_SPARE, $urandom);
            end

            case ($urandom_range(0, 2))
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 8;
                default: tx_idle_pct = 25;
            endcase
            case ($urandom_range(0, 2))
                0: roll = 0;
                1: roll = 8;
                default: roll = 25;
            endcase
            if (quiet) begin
                tx_idle_pct = 0;
                roll        = 0;
            end
            rx_idle_pct <= roll;

            // now and then keep the old maze and only resize the query window
            if ($urandom_range(0, 9) != 0) begin
                send_item(OP_GENERATE, 6'($urandom), 6'($urandom),
                          dir_t'($urandom_range(0, 3)), 1'b0, '0);
            end
            if (phase == 1) begin
                // reply side holds off while queries keep coming
                wait_replies();
                tx_idle_pct = 0;
                hold_asks <= hold_asks + 1;
            end

            batch = $urandom_range(20, 60);
            for (int k = 0; k < batch && items_sent < ITEM_TARGET; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    send_item(OP_GENERATE, 6'($urandom), 6'($urandom),
                              dir_t'($urandom_range(0, 3)), 1'b0, '0);
                end else if (roll < 4 && !quiet) begin
                    wait_replies();
                end else begin
                    w = fit_dim(cfg_cols, COLS);
                    h = fit_dim(cfg_rows, ROWS);
                    if ($urandom_range(0, 4) != 0) begin
                        x = 6'($urandom_range(0, w - 1));
                        send_item(OP_QUERY, x, 6'($urandom_range(0, h - 1)),
                                  dir_t'($urandom_range(0, 3)), 1'b0, '0);
                    end else begin
                        send_item(OP_QUERY, 6'($urandom), 6'($urandom),
                                  dir_t'($urandom_range(0, 3)), 1'b0, '0);
                    end
                end
            end
            phase++;
        end

        wait_replies();
        repeat (16) @(posedge aclk);
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mbg_pkg.sv
hw/rtl/mbg_ram.sv
hw/rtl/mbg_ctrl.sv
hw/rtl/maze_backtracker_generator_top.sv
dv/tb_maze_backtracker_generator_top.sv
